/* hw/rtl/obstacle_safety_monitor_unit_defines.svh */
// Assertion macros for the obstacle safety monitor.
`ifndef OBSTACLE_SAFETY_MONITOR_UNIT_DEFINES_SVH
`define OBSTACLE_SAFETY_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on i_clk, off during reset
`define OSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/osm_pkg.sv */
// Types, constants and the sine table builder for the obstacle safety monitor.
package osm_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_CONF  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RANGE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LANE_HALF = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REACTION  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DECEL = 3'd4;

    localparam logic [16:0] CONF_ONE     = 17'd65536;
    localparam logic [4:0]  ROOT_STEPS   = 5'd20;
    // brake test scaled by 1/72: f*a*41472 <= spd*rt*a*45 + spd^2*1600
    localparam logic [15:0] LHS_K        = 16'd41472;
    localparam logic [5:0]  T1_K         = 6'd45;
    localparam logic [10:0] T2_K         = 11'd1600;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned Term_Div [1:20] = '{
        6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
        506, 600, 702, 812, 930, 1056, 1190, 1332, 1482, 1640};

    typedef struct packed {
        logic [15:0]        det_id;
        logic signed [19:0] forward_dist;
        logic signed [19:0] left_dist;
        logic [16:0]        confidence;
        logic [15:0]        heading;
        logic signed [23:0] rover_x;
        logic signed [23:0] rover_y;
        logic [15:0]        speed;
        logic               frame_last;
    } t_det;

    typedef struct packed {
        logic               accepted;
        logic [15:0]        obstacle_id;
        logic signed [23:0] world_x;
        logic signed [23:0] world_y;
        logic [19:0]        obstacle_range;
        logic               in_brake_zone;
        logic               frame_done;
        logic               nearest_found;
        logic [15:0]        nearest_id;
        logic [19:0]        nearest_range;
        logic               emergency_brake;
    } t_res;

    typedef struct packed {
        logic load;
        logic calc1;
        logic calc2;
        logic root_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // Q15 sine of a quarter-wave index, integer Taylor series in Q30
    function automatic logic [15:0] quarter_sin(input longint unsigned m,
                                                input int unsigned bits);
        longint unsigned x, x2, s, t, r;
        x  = (m * PI_Q30 * 64'd2 + ((64'd1 << bits) >> 1)) >> bits;
        x2 = (x * x) >> 30;
        s  = x;
        t  = x;
        for (int n = 1; n <= 20; n++) begin
            if (t != 0) begin
                t = ((t * x2) >> 30) / Term_Div[n];
                if (n % 2 == 1) s = s - t;
                else            s = s + t;
            end
        end
        r = (s + 64'd16384) >> 15;
        if (r > 64'd32768) r = 64'd32768;
        return r[15:0];
    endfunction

endpackage

/* hw/rtl/osm_ctrl.sv */
// Sequencer for one detection: products, square root steps, result write.
module osm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_det_valid,
    input  osm_pkg::t_sts  i_sts,
    output osm_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import osm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CALC1, S_CALC2, S_ROOT, S_DONE} t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_det_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC1;
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_cnt       = '0;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 5'd1;
                if (r_cnt == ROOT_STEPS - 5'd1) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* hw/rtl/osm_dp.sv */
// Datapath: config registers, products, bit-serial square root, frame summary.
module osm_dp #(
    parameter int ID_BITS          = 16,
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [osm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [osm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  osm_pkg::t_det                 i_det,
    input  osm_pkg::t_cmd                 i_cmd,
    output osm_pkg::t_sts                 o_sts,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output osm_pkg::t_res                 o_res
);
    import osm_pkg::*;

    localparam int AB = ANGLE_TABLE_BITS;
    localparam int QN = 1 << (AB - 2);
    localparam logic [15:0] ID_MASK =
        (ID_BITS >= 16) ? 16'hFFFF : 16'(((32'd1 << ID_BITS) - 32'd1));

    // quarter-wave sine table, QN+1 entries
    logic [15:0] w_tab [0:QN];
    for (genvar g = 0; g <= QN; g++) begin : g_tab
        localparam logic [15:0] V = quarter_sin(longint'(g), AB);
        assign w_tab[g] = V;
    end

    logic [16:0] r_min_conf;
    logic [19:0] r_max_range;
    logic [15:0] r_lane_half;
    logic [11:0] r_reaction;
    logic [12:0] r_decel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf  <= 17'd32768;
            r_max_range <= 20'd25600;
            r_lane_half <= 16'd256;
            r_reaction  <= 12'd128;
            r_decel     <= 13'd1536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_CONF:  r_min_conf  <= i_cfg_wdata[16:0];
                CFG_MAX_RANGE: r_max_range <= i_cfg_wdata;
                CFG_LANE_HALF: r_lane_half <= i_cfg_wdata[15:0];
                CFG_REACTION:  r_reaction  <= i_cfg_wdata[11:0];
                CFG_MAX_DECEL: r_decel     <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    t_det r_det;

    // sine / cosine lookup
    logic [AB-1:0]        w_idx, w_cidx;
    logic signed [16:0]   w_sin, w_cos;

    function automatic logic signed [16:0] sin_lookup(input logic [AB-1:0] idx,
                                                      input logic [15:0] tab [0:QN]);
        logic [AB-3:0]      r;
        logic [AB-2:0]      k;
        logic [15:0]        mag;
        r = idx[AB-3:0];
        if (idx[AB-2]) k = (AB-1)'(QN) - {1'b0, r};
        else           k = {1'b0, r};
        mag = tab[k];
        return idx[AB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    assign w_idx  = r_det.heading[15 -: AB];
    assign w_cidx = w_idx + AB'(QN);
    assign w_sin  = sin_lookup(w_idx, w_tab);
    assign w_cos  = sin_lookup(w_cidx, w_tab);

    logic [12:0] w_decel;
    assign w_decel = (r_decel == '0) ? 13'd1 : r_decel;

    // first products
    logic [39:0]        r_ff, r_ll, r_mr2;
    logic signed [16:0] r_sin, r_cos;
    logic [31:0]        r_fa;
    logic [27:0]        r_sr;
    logic [31:0]        r_ss;
    // second products
    logic [39:0]        r_sum, r_src;
    logic signed [36:0] r_cf, r_sl, r_sf, r_cl;
    logic [47:0]        r_lhs;
    logic [40:0]        r_t1;
    logic [42:0]        r_t2;
    // during root steps
    logic signed [37:0] r_px, r_py;
    logic [47:0]        r_rhs;
    logic [22:0]        r_rem;
    logic [19:0]        r_root;

    logic signed [39:0] w_f2, w_l2;
    assign w_f2 = r_det.forward_dist * r_det.forward_dist;
    assign w_l2 = r_det.left_dist * r_det.left_dist;

    logic [22:0] w_rem_sh, w_trial;
    assign w_rem_sh = {r_rem[20:0], r_src[39:38]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_det <= i_det;
        if (i_cmd.calc1) begin
            r_ff  <= 40'(unsigned'(w_f2));
            r_ll  <= 40'(unsigned'(w_l2));
            r_mr2 <= r_max_range * r_max_range;
            r_sin <= w_sin;
            r_cos <= w_cos;
            r_fa  <= r_det.forward_dist[18:0] * w_decel;
            r_sr  <= r_det.speed * r_reaction;
            r_ss  <= r_det.speed * r_det.speed;
        end
        if (i_cmd.calc2) begin
            r_sum  <= r_ff + r_ll;
            r_src  <= r_ff + r_ll;
            r_rem  <= '0;
            r_root <= '0;
            r_cf   <= r_cos * r_det.forward_dist;
            r_sl   <= r_sin * r_det.left_dist;
            r_sf   <= r_sin * r_det.forward_dist;
            r_cl   <= r_cos * r_det.left_dist;
            r_lhs  <= r_fa * LHS_K;
            r_t1   <= r_sr * w_decel;
            r_t2   <= r_ss * T2_K;
        end
        if (i_cmd.root_step) begin
            r_px  <= 38'(r_cf) - 38'(r_sl);
            r_py  <= 38'(r_sf) + 38'(r_cl);
            r_rhs <= 48'(r_t1) * T1_K + 48'(r_t2);
            r_src <= {r_src[37:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[18:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[18:0], 1'b0};
            end
        end
    end

    function automatic logic signed [23:0] place(input logic signed [37:0] p,
                                                 input logic signed [23:0] base);
        logic signed [38:0] b;
        logic signed [25:0] v;
        b = 39'(p) + 39'sd16384;
        v = 26'(b >>> 15) + 26'(base);
        if (v > 26'sd8388607)       return 24'sd8388607;
        else if (v < -26'sd8388608) return -24'sd8388608;
        else                        return v[23:0];
    endfunction

    // result formation
    logic        w_acc, w_brake, w_upd;
    logic [19:0] w_absl;
    assign w_acc = (r_det.confidence >= r_min_conf) && (r_det.confidence <= CONF_ONE) &&
                   (r_sum != '0) && (r_sum <= r_mr2);
    assign w_absl = r_det.left_dist[19] ? 20'(-r_det.left_dist) : r_det.left_dist;
    assign w_brake = w_acc && !r_det.forward_dist[19] &&
                     ({1'b0, w_absl} <= {5'd0, r_lane_half}) && (r_lhs <= r_rhs);

    logic        r_best_found, r_brake_seen;
    logic [15:0] r_best_id;
    logic [19:0] r_best_range;
    logic        w_bf, w_bs;
    logic [15:0] w_bid;
    logic [19:0] w_br;

    assign w_upd = w_acc && (!r_best_found || r_root < r_best_range);
    assign w_bf  = r_best_found | w_acc;
    assign w_bid = w_upd ? (r_det.det_id & ID_MASK) : r_best_id;
    assign w_br  = w_upd ? r_root : r_best_range;
    assign w_bs  = r_brake_seen | w_brake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
            r_brake_seen <= 1'b0;
            r_best_id    <= '0;
            r_best_range <= '0;
        end else if (i_cmd.finish) begin
            if (r_det.frame_last) begin
                r_best_found <= 1'b0;
                r_brake_seen <= 1'b0;
                r_best_id    <= '0;
                r_best_range <= '0;
            end else begin
                r_best_found <= w_bf;
                r_brake_seen <= w_bs;
                r_best_id    <= w_bid;
                r_best_range <= w_br;
            end
        end
    end

    logic r_out_valid;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res.accepted        <= w_acc;
            r_res.obstacle_id     <= r_det.det_id & ID_MASK;
            r_res.world_x         <= w_acc ? place(r_px, r_det.rover_x) : '0;
            r_res.world_y         <= w_acc ? place(r_py, r_det.rover_y) : '0;
            r_res.obstacle_range  <= r_root;
            r_res.in_brake_zone   <= w_brake;
            r_res.frame_done      <= r_det.frame_last;
            r_res.nearest_found   <= r_det.frame_last & w_bf;
            r_res.nearest_id      <= (r_det.frame_last && w_bf) ? w_bid : '0;
            r_res.nearest_range   <= (r_det.frame_last && w_bf) ? w_br : '0;
            r_res.emergency_brake <= r_det.frame_last & w_bs;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_res_stall;
    assign o_res_valid    = r_out_valid;
    assign o_res          = r_res;

endmodule

/* hw/rtl/obstacle_safety_monitor_unit.sv */
// Top level of the obstacle safety monitor: sequencer plus datapath.
//
//  channel  direction  handshake                 beat
//  det      in         i_det_valid / o_det_stall  t_det, one detection
//  res      out        o_res_valid / i_res_stall  t_res, one result
//  cfg      in         i_cfg_we                   index + data, no wait
//
// A result is presented after its detection passes the load, both product steps,
// the 20-step bit-serial square root and the result write. A new beat is taken
// only after the previous detection has written its result.
// A held result stalls only the final write; the next detection enters after that write.
// Reset (synchronous, active low) restores config defaults and clears the summary.
`include "obstacle_safety_monitor_unit_defines.svh"
module obstacle_safety_monitor_unit #(
    parameter int ID_BITS          = 16,
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [osm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [osm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_det_valid,
    output logic                           o_det_stall,
    input  osm_pkg::t_det                  i_det,
    output logic                           o_res_valid,
    input  logic                           i_res_stall,
    output osm_pkg::t_res                  o_res
);
    import osm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    osm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_det_valid (i_det_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy)
    );

    osm_dp #(
        .ID_BITS          (ID_BITS),
        .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_det       (i_det),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    assign o_det_stall = w_busy;

    `OSM_ASSERT_NXT(a_busy_after_accept, i_det_valid && !o_det_stall, o_det_stall, "not busy after accepted beat")
    `OSM_ASSERT_IMP(a_brake_needs_accept, o_res_valid && o_res.in_brake_zone, o_res.accepted, "brake zone on rejected detection")
    `OSM_ASSERT_IMP(a_summary_only_last, o_res_valid && !o_res.frame_done, !o_res.nearest_found && !o_res.emergency_brake, "summary outside frame end")
    `OSM_ASSERT_NXT(a_finish_gives_valid, w_cmd.finish, o_res_valid, "result not presented after finish")

endmodule

/* test/obstacle_safety_monitor_unit_tb.sv */
// Self-checking testbench for the obstacle safety monitor: directed, config sweep and random frames.
module obstacle_safety_monitor_unit_tb;
    import osm_pkg::*;

    localparam int WDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DET_W = $bits(t_det);
    // indexes past the register list, expected to be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_det_valid;
    logic                  o_det_stall;
    t_det                  i_det;
    logic                  o_res_valid;
    logic                  i_res_stall;
    t_res                  o_res;

    obstacle_safety_monitor_unit uut (.*);

    // shadow config and frame summary
    logic [16:0] min_conf_q;
    logic [19:0] max_range_q;
    logic [15:0] lane_half_q;
    logic [11:0] react_q;
    logic [12:0] decel_q;
    logic        nb_found;
    logic [15:0] nb_id;
    logic [19:0] nb_range;
    logic        brake_flag;

    t_res pending_res[$];
    bit   failed;
    bit   idle_en;
    int   stall_burst;
    int   quiet_cycles;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q15 sine over a quarter wave, Taylor series in Q30
    function automatic longint quarter_wave(input longint unsigned m);
        longint unsigned x, x2, acc, term, q;
        x = (m * 64'd3373259426 * 64'd2 + 64'd512) >> 10;
        x2 = (x * x) >> 30;
        acc = x;
        term = x;
        for (int n = 1; n <= 20; n++) begin
            if (term != 0) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
        end
        q = (acc + 64'd16384) >> 15;
        if (q > 64'd32768) q = 64'd32768;
        return longint'(q);
    endfunction

    function automatic longint sine_q15(input logic [9:0] idx);
        longint mag;
        mag = idx[8] ? quarter_wave(256 - idx[7:0]) : quarter_wave(idx[7:0]);
        return idx[9] ? -mag : mag;
    endfunction

    function automatic longint sat_world(input longint base, input longint prod);
        longint v;
        v = base + ((prod + 16384) >>> 15);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v;
    endfunction

    // expected result of one detection; updates the frame summary
    function automatic t_res safety_eval(input t_det d);
        t_res r;
        longint f, l, al, s, c;
        longint unsigned sq, rng, a, num, den, spd;
        logic [9:0] idx;
        r = '0;
        f = longint'(d.forward_dist);
        l = longint'(d.left_dist);
        sq = longint'(f * f + l * l);
        rng = int_sqrt(sq);
        if (rng > 20'hFFFFF) rng = 20'hFFFFF;
        r.obstacle_id = d.det_id;
        r.obstacle_range = rng[19:0];
        r.accepted = d.confidence >= min_conf_q && d.confidence <= CONF_ONE && sq > 0
                     && sq <= longint'(max_range_q) * longint'(max_range_q);
        if (r.accepted) begin
            idx = d.heading[15:6];
            s = sine_q15(idx);
            c = sine_q15(idx + 10'd256);
            r.world_x = 24'(sat_world(longint'(d.rover_x), c * f - s * l));
            r.world_y = 24'(sat_world(longint'(d.rover_y), s * f + c * l));
            a = (decel_q == 0) ? 1 : decel_q;
            spd = d.speed;
            num = 5 * spd * react_q * 648 * a + 25 * spd * spd * 4608;
            den = 4608 * 648 * a;
            al = (l < 0) ? -l : l;
            r.in_brake_zone = f >= 0 && al <= lane_half_q && longint'(f) * den <= num;
            if (!nb_found || rng < nb_range) begin
                nb_found = 1'b1;
                nb_id = d.det_id;
                nb_range = rng[19:0];
            end
            if (r.in_brake_zone) brake_flag = 1'b1;
        end
        r.frame_done = d.frame_last;
        if (d.frame_last) begin
            r.nearest_found = nb_found;
            r.nearest_id = nb_found ? nb_id : 16'd0;
            r.nearest_range = nb_found ? nb_range : 20'd0;
            r.emergency_brake = brake_flag;
            nb_found = 1'b0;
            nb_id = '0;
            nb_range = '0;
            brake_flag = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string nm, input longint e, input longint a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
            failed = 1'b1;
        end
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result beat, got %h", $time, o_res);
                failed = 1'b1;
            end else begin
                e = pending_res.pop_front();
                check_field("accepted", longint'(e.accepted), longint'(o_res.accepted));
                check_field("obstacle_id", longint'(e.obstacle_id),
                            longint'(o_res.obstacle_id));
                check_field("world_x", longint'(e.world_x), longint'(o_res.world_x));
                check_field("world_y", longint'(e.world_y), longint'(o_res.world_y));
                check_field("obstacle_range", longint'(e.obstacle_range),
                            longint'(o_res.obstacle_range));
                check_field("in_brake_zone", longint'(e.in_brake_zone),
                            longint'(o_res.in_brake_zone));
                check_field("frame_done", longint'(e.frame_done), longint'(o_res.frame_done));
                check_field("nearest_found", longint'(e.nearest_found),
                            longint'(o_res.nearest_found));
                check_field("nearest_id", longint'(e.nearest_id), longint'(o_res.nearest_id));
                check_field("nearest_range", longint'(e.nearest_range),
                            longint'(o_res.nearest_range));
                check_field("emergency_brake", longint'(e.emergency_brake),
                            longint'(o_res.emergency_brake));
            end
        end
    end

    // result-side stall bursts
    always @(negedge i_clk) begin
        if (!idle_en) begin
            i_res_stall <= 1'b0;
            stall_burst <= 0;
        end else if (stall_burst > 0) begin
            i_res_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_res_stall <= 1'b1;
            stall_burst <= $urandom_range(0, 5);
        end else begin
            i_res_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_det_valid && !o_det_stall) || (o_res_valid && !i_res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_det(input t_det d);
        int gap;
        @(negedge i_clk);
        i_det_valid <= 1'b1;
        i_det <= d;
        do @(posedge i_clk); while (o_det_stall);
        pending_res = {pending_res, safety_eval(d)};
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_det_valid <= 1'b0;
            i_det <= t_det'(DET_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_det_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [19:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        case (addr)
            CFG_MIN_CONF:  min_conf_q = val[16:0];
            CFG_MAX_RANGE: max_range_q = val;
            CFG_LANE_HALF: lane_half_q = val[15:0];
            CFG_REACTION:  react_q = val[11:0];
            CFG_MAX_DECEL: decel_q = val[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all_cfg(input int mc, input int mr, input int lh, input int rt,
                               input int dc);
        write_cfg(CFG_MIN_CONF, 20'(mc));
        write_cfg(CFG_MAX_RANGE, 20'(mr));
        write_cfg(CFG_LANE_HALF, 20'(lh));
        write_cfg(CFG_REACTION, 20'(rt));
        write_cfg(CFG_MAX_DECEL, 20'(dc));
    endtask

    function automatic t_det mk_det(input int id, input int f, input int l, input int conf,
                                    input int head, input int rx, input int ry,
                                    input int spd, input bit last);
        t_det d;
        d.det_id = id[15:0];
        d.forward_dist = f[19:0];
        d.left_dist = l[19:0];
        d.confidence = conf[16:0];
        d.heading = head[15:0];
        d.rover_x = rx[23:0];
        d.rover_y = ry[23:0];
        d.speed = spd[15:0];
        d.frame_last = last;
        return d;
    endfunction

    task automatic test_directed();
        send_det(mk_det(1, 1000, 0, 65536, 0, 0, 0, 9216, 0));           // in brake zone
        send_det(mk_det(2, 0, 0, 65536, 0, 0, 0, 9216, 0));              // zero range
        send_det(mk_det(3, 1000, 0, 65537, 0, 0, 0, 9216, 0));           // confidence above one
        send_det(mk_det(4, 1000, 0, 32767, 0, 0, 0, 9216, 0));           // just under minimum
        send_det(mk_det(5, 1000, 0, 32768, 16384, 100, -100, 0, 1));     // frame end
        send_det(mk_det(6, 25600, 0, 40000, 32768, 0, 0, 65535, 0));     // range at maximum
        send_det(mk_det(7, 0, 25601, 40000, 49152, 0, 0, 65535, 0));     // just past maximum
        send_det(mk_det(8, -524288, -524288, 131071, 65535, 0, 0, 0, 0));
        send_det(mk_det(9, 524287, 524287, 0, 0, 0, 0, 0, 1));           // frame end, rejected
        send_det(mk_det(10, 1, 0, 1, 0, 0, 0, 0, 1));
        send_det(mk_det(11, 20000, 256, 65536, 8192, 8388607, 8388607, 65535, 0));
        send_det(mk_det(12, -20000, -257, 65536, 40960, -8388608, -8388608, 65535, 0));
        send_det(mk_det(13, 20000, 100, 65536, 8192, 8388607, 8388607, 65535, 0)); // nearer than 11
        send_det(mk_det(65535, 3000, -256, 50000, 24576, 0, 0, 30000, 1));
        wait_idle();
    endtask

    task automatic test_config_sweep();
        // zero deceleration, open limits
        set_all_cfg(0, 20'hFFFFF, 16'hFFFF, 12'hFFF, 0);
        write_cfg(CFG_SPARE_LO, 20'h12345);
        write_cfg(CFG_SPARE_HI, 20'hFFFFF);
        send_det(mk_det(20, 524287, 0, 0, 0, 0, 0, 65535, 0));
        send_det(mk_det(21, 400000, -524288, 65536, 12345, -5000, 5000, 100, 0));
        send_det(mk_det(22, 1, 0, 0, 0, 0, 0, 0, 1));
        wait_idle();
        set_all_cfg(65536, 0, 0, 0, 1);
        send_det(mk_det(23, 1, 0, 65536, 0, 0, 0, 1, 0));
        send_det(mk_det(24, 0, 1, 65536, 0, 0, 0, 1, 1));
        wait_idle();
        set_all_cfg(20'h1FFFF, 20'hFFFFF, 0, 4095, 8191);
        send_det(mk_det(25, 5, 0, 65536, 0, 0, 0, 65535, 1));
        wait_idle();
    endtask

    function automatic int pick_signed(input int span, input int bits);
        if ($urandom_range(0, 9) == 0) return int'({$urandom} << (32 - bits)) >>> (32 - bits);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic test_random_frames(input int n_items);
        int sent, flen, head, rx, ry, spd, lim, conf;
        sent = 0;
        while (sent < n_items) begin
            flen = $urandom_range(1, 30);
            head = $urandom_range(0, 65535);
            rx = int'($urandom << 8) >>> 8;
            ry = $urandom_range(0, 3) == 0 ? int'($urandom << 8) >>> 8
                                           : $urandom_range(0, 20000) - 10000;
            spd = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 12000);
            lim = (max_range_q > 30000 || max_range_q == 0) ? 30000 : max_range_q + 100;
            for (int k = 0; k < flen && sent < n_items; k++) begin
                case ($urandom_range(0, 4))
                    0: conf = $urandom_range(0, 131071);
                    1: conf = 65536 - $urandom_range(0, 3);
                    default: conf = $urandom_range(min_conf_q > 65536 ? 65536 : min_conf_q,
                                                   65536);
                endcase
                send_det(mk_det($urandom_range(0, 65535),
                                $urandom_range(0, 2) == 0 ? pick_signed(lim, 20)
                                                          : $urandom_range(0, 4000),
                                $urandom_range(0, 1) ? pick_signed(lim, 20)
                                                     : pick_signed(lane_half_q + 50, 20),
                                conf, head, rx, ry, spd,
                                (k == flen - 1) || $urandom_range(0, 40) == 0));
                sent++;
            end
        end
        wait_idle();
    endtask

    initial begin
        failed = 1'b0;
        idle_en = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_det_valid = 1'b0;
        i_det = '0;
        i_res_stall = 1'b0;
        stall_burst = 0;
        min_conf_q = 17'd32768;
        max_range_q = 20'd25600;
        lane_half_q = 16'd256;
        react_q = 12'd128;
        decel_q = 13'd1536;
        nb_found = 1'b0;
        nb_id = '0;
        nb_range = '0;
        brake_flag = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        test_directed();
        test_config_sweep();
        set_all_cfg(32768, 25600, 256, 128, 1536);
        test_random_frames(450);
        set_all_cfg($urandom_range(0, 65536), $urandom_range(1000, 60000),
                    $urandom_range(0, 2000), $urandom_range(0, 4095), $urandom_range(1, 8191));
        test_random_frames(450);
        set_all_cfg($urandom_range(0, 131071), $urandom_range(0, 1048575),
                    $urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(0, 8191));
        test_random_frames(450);
        set_all_cfg(0, 20'hFFFFF, 16'hFFFF, 4095, 1);
        test_random_frames(250);
        idle_en = 1'b0;
        set_all_cfg(16384, 8000, 512, 300, 800);
        test_random_frames(250);

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
